### rtl/pgrep_pkg.sv
package pgrep_pkg;

    localparam int PAGE_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int FRAMES_W = 4;
    localparam int CFG_W    = 4;
    localparam int CFG_AW   = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_AW-1:0] REG_FRAME_COUNT = 1'd0;
    localparam logic [CFG_AW-1:0] REG_POLICY_MODE = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 4'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } pgrep_mem_ctl_t;

endpackage

### rtl/pgrep_frame_store.sv
module pgrep_frame_store
    import pgrep_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int PW    = 16
) (
    input  logic           aclk,
    input  pgrep_mem_ctl_t ctl,
    input  logic [AW-1:0]  rd_addr,
    input  logic [AW-1:0]  wr_addr,
    input  logic [PW-1:0]  wr_data,
    input  logic [PW-1:0]  key,
    output logic [PW-1:0]  rd_data,
    output logic           match
);

    logic [PW-1:0] mem [DEPTH];
    logic [PW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign match   = (rd_data_reg == key);

endmodule

### rtl/page_replacement_fifo_lru.sv
// Channel  Direction  tdata (low bit up)                           tuser / tlast
// s_       in         page_number[15:0]                            tlast: last_in_string
// m_       out        fault_total, victim_page, resident_count,    tuser: page_fault,
//                     4 zero bits                                  victim_valid
// cfg_     in         index 0 frame_count, index 1 policy_mode     -
// Each word takes a search pass over the resident frames (up to MAX_FRAMES) and, for an LRU
// hit or an eviction, a shift pass, both through the single frame store with its one read
// port, one write port and registered read. s_tready is high only between words.
// Reset (aresetn low, synchronous) empties the frames and clears the fault count.
// A stalled result holds in the output register; the next word is searched meanwhile
// and its result waits until the register drains.
module page_replacement_fifo_lru
    import pgrep_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // page_number[15:0]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // fault_total[15:0], victim_page[31:16],
                                         // resident_count[35:32], zero[39:36]
    output logic [1:0]        m_tuser,   // page_fault[0], victim_valid[1]
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OCW = $clog2(MAX_FRAMES + 1);
    localparam int PW  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CFG_W-1:0]    frame_count_reg;
    logic                policy_mode_reg;
    logic [PW-1:0]       page_reg, page_next;
    logic                last_reg, last_next;
    logic                lru_reg, lru_next;
    logic [OCW-1:0]      limit_reg, limit_next, limit_c;
    logic [OCW-1:0]      occ_reg, occ_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [OCW-1:0]      idx_reg, idx_next;
    logic [OCW-1:0]      wr_idx_reg, wr_idx_next;
    logic [OCW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                pend_reg, pend_next;
    logic                hit_reg, hit_next;
    logic                vic_vld_reg, vic_vld_next;
    logic [PW-1:0]       vic_reg, vic_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_fault_reg, m_fault_next;
    logic [COUNT_W-1:0]  m_total_reg, m_total_next;
    logic                m_vv_reg, m_vv_next;
    logic [PAGE_W-1:0]   m_vp_reg, m_vp_next;
    logic [FRAMES_W-1:0] m_res_reg, m_res_next;

    pgrep_mem_ctl_t      mem_ctl;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [PW-1:0]       wr_data, rd_data;
    logic                match;

    pgrep_frame_store #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW),
        .PW    (PW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .key     (page_reg),
        .rd_data (rd_data),
        .match   (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= FRAME_COUNT_RST;
            policy_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_COUNT: frame_count_reg <= cfg_wdata;
                REG_POLICY_MODE: policy_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_count_reg == '0) begin
            limit_c = OCW'(1);
        end else if (int'(frame_count_reg) > MAX_FRAMES) begin
            limit_c = OCW'(MAX_FRAMES);
        end else begin
            limit_c = OCW'(frame_count_reg);
        end
    end

    assign cnt_inc = hit_reg ? cnt_reg :
                     ((cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1);

    always_comb begin
        state_next    = state_reg;
        page_next     = page_reg;
        last_next     = last_reg;
        lru_next      = lru_reg;
        limit_next    = limit_reg;
        occ_next      = occ_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        wr_idx_next   = wr_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        vic_vld_next  = vic_vld_reg;
        vic_next      = vic_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_fault_next  = m_fault_reg;
        m_total_next  = m_total_reg;
        m_vv_next     = m_vv_reg;
        m_vp_next     = m_vp_reg;
        m_res_next    = m_res_reg;
        mem_ctl       = '0;
        rd_addr       = idx_reg[AW-1:0];
        wr_addr       = wr_idx_reg[AW-1:0];
        wr_data       = page_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    page_next    = s_tdata[PW-1:0];
                    last_next    = s_tlast;
                    lru_next     = policy_mode_reg;
                    limit_next   = limit_c;
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    hit_next     = 1'b0;
                    vic_vld_next = 1'b0;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (pend_reg && cmp_idx_reg == '0) begin
                    vic_next = rd_data;
                end
                if (pend_reg && match) begin
                    hit_next  = 1'b1;
                    pend_next = 1'b0;
                    if (lru_reg) begin
                        wr_idx_next = cmp_idx_reg;
                        idx_next    = cmp_idx_reg + 1'b1;
                        state_next  = ST_SHIFT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (idx_reg < occ_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    cmp_idx_next  = idx_reg;
                    idx_next      = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    if (occ_reg < limit_reg) begin
                        // append into a free frame
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = occ_reg[AW-1:0];
                        occ_next      = occ_reg + 1'b1;
                        state_next    = ST_FINISH;
                    end else begin
                        // evict the front frame
                        vic_vld_next = 1'b1;
                        wr_idx_next  = '0;
                        idx_next     = OCW'(1);
                        state_next   = ST_SHIFT;
                    end
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_SHIFT: begin
                if (pend_reg) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_data       = rd_data;
                    wr_idx_next   = wr_idx_reg + 1'b1;
                end
                if (idx_reg < occ_reg) begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && idx_reg >= occ_reg) begin
                    mem_ctl.wr_en = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_fault_next  = ~hit_reg;
                    m_total_next  = cnt_inc;
                    m_vv_next     = vic_vld_reg;
                    m_vp_next     = vic_vld_reg ? PAGE_W'(vic_reg) : '0;
                    m_res_next    = FRAMES_W'(occ_reg);
                    cnt_next      = last_reg ? '0 : cnt_inc;
                    occ_next      = last_reg ? '0 : occ_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg    <= page_next;
        last_reg    <= last_next;
        lru_reg     <= lru_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
        wr_idx_reg  <= wr_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        vic_vld_reg <= vic_vld_next;
        vic_reg     <= vic_next;
        m_fault_reg <= m_fault_next;
        m_total_reg <= m_total_next;
        m_vv_reg    <= m_vv_next;
        m_vp_reg    <= m_vp_next;
        m_res_reg   <= m_res_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_res_reg, m_vp_reg, m_total_reg};
    assign m_tuser  = {m_vv_reg, m_fault_reg};

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(occ_reg) <= MAX_FRAMES)
        else $error("occupancy beyond frame capacity");

    a_victim_is_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("eviction reported on a hit");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[31:16] == '0)
        else $error("victim page not zero without eviction");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while previous still in work");
`endif

endmodule
